FILE: hw/rtl/lmsb_pkg.sv
// Shared constants, codes, port structs and helpers for the LED matrix scan block.
package lmsb_pkg;

  localparam int ROWS          = 8;
  localparam int BYTES_PER_ROW = 3;
  localparam int FRAME_BYTES   = 24;

  localparam int MARK_IDX_A = 10;
  localparam int MARK_IDX_B = 13;
  localparam logic [7:0] MARK_BYTE = 8'h18;

  localparam int SCAN_SPAN = (ROWS * BYTES_PER_ROW > FRAME_BYTES) ?
                             ROWS * BYTES_PER_ROW : FRAME_BYTES;
  localparam int ROW_W  = $clog2(ROWS);
  localparam int CNT_W  = $clog2(FRAME_BYTES + 1);
  localparam int MEM_AW = $clog2(FRAME_BYTES);
  localparam int ADDR_W = $clog2(SCAN_SPAN + 1);
  localparam int BC_W   = $clog2(BYTES_PER_ROW + 1);

  typedef enum logic [2:0] {
    CMD_START     = 3'd0,
    CMD_WRITE     = 3'd1,
    CMD_READ_ADDR = 3'd2,
    CMD_READ_NEXT = 3'd3,
    CMD_SCAN      = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_LATCH = 2'd0,
    KIND_SHIFT = 2'd1,
    KIND_REPLY = 2'd2
  } kind_e;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } mem_wr_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } mem_rd_t;

  // Power-on contents of one frame entry
  function automatic logic [7:0] frame_init(logic [MEM_AW-1:0] idx);
    logic [7:0] v;
    v = 8'h00;
    if (32'(idx) == MARK_IDX_A || 32'(idx) == MARK_IDX_B) v = MARK_BYTE;
    return v;
  endfunction

  function automatic logic [2:0] row_field(logic [ROW_W-1:0] row);
    logic [15:0] wide;
    wide = 16'(row);
    return wide[2:0];
  endfunction

  function automatic logic [4:0] count_field(logic [CNT_W-1:0] cnt);
    logic [15:0] wide;
    wide = 16'(cnt);
    return wide[4:0];
  endfunction

endpackage

FILE: hw/rtl/led_matrix_scan_with_bus_loaded_frame_core.sv
// Top level: bus-loaded frame store and row scan sequencer for a multiplexed LED matrix.
// Items arrive one at a time. Bus commands (start, write, reads) are handled while idle and
// a read reply leaves through the output register; a scan tick gives a latch/row-select
// result and then ROWS-independent 8 * BYTES_PER_ROW serial bits, one per cycle while the
// output is not stalled, so a scan tick occupies the block until its last bit is loaded.
// The bit rate is set by the single output register, which carries one result per
// cycle when not stalled; the frame-store read port fetches the next row byte during the
// last bit slot of the current one, so it never slows the bits. Input stall is held while a
// scan is in progress or the output register cannot be loaded.
module led_matrix_scan_with_bus_loaded_frame_core
  import lmsb_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] in_cmd_i,
  input  logic [7:0] in_data_byte_i,
  input  logic       in_master_ack_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] out_kind_o,
  output logic [2:0] out_row_select_o,
  output logic       out_serial_bit_o,
  output logic [4:0] out_read_data_o,
  output logic       out_last_o
);

  typedef enum logic {
    S_IDLE,
    S_BITS
  } state_e;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [ROW_W-1:0]  row_next;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [BC_W-1:0]   bcnt_q, bcnt_d;
  logic [2:0]        bit_q, bit_d;
  logic [7:0]        sh_q, sh_d;

  logic              out_valid_q, out_valid_d;
  kind_e             kind_q, kind_d;
  logic [2:0]        rsel_q, rsel_d;
  logic              sbit_q, sbit_d;
  logic [4:0]        rdat_q, rdat_d;
  logic              last_q, last_d;

  logic              out_free;
  logic              in_accept;
  logic              last_bit;
  mem_wr_t           mem_wr;
  mem_rd_t           mem_rd;
  logic [7:0]        mem_rdata;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign row_next   = (row_q == ROW_W'(ROWS - 1)) ? '0 : row_q + 1'b1;
  assign last_bit   = (bcnt_q == BC_W'(BYTES_PER_ROW - 1)) && (bit_q == 3'd7);

  lmsb_frame_mem u_frame_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (mem_wr),
    .rd_i      (mem_rd),
    .rd_data_o (mem_rdata)
  );

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    row_d       = row_q;
    addr_d      = addr_q;
    bcnt_d      = bcnt_q;
    bit_d       = bit_q;
    sh_d        = sh_q;
    out_valid_d = out_valid_q && out_stall_i;
    kind_d      = kind_q;
    rsel_d      = rsel_q;
    sbit_d      = sbit_q;
    rdat_d      = rdat_q;
    last_d      = last_q;
    mem_wr      = '{en: 1'b0, addr: ADDR_W'(cnt_q), data: in_data_byte_i};
    mem_rd      = '{en: 1'b0, addr: addr_q};

    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          case (cmd_e'(in_cmd_i))
            CMD_START: begin
              cnt_d = '0;
            end
            CMD_WRITE: begin
              if (cnt_q < CNT_W'(FRAME_BYTES)) begin
                mem_wr.en = 1'b1;
                cnt_d     = cnt_q + 1'b1;
              end
            end
            CMD_READ_ADDR, CMD_READ_NEXT: begin
              if (in_cmd_i == CMD_READ_ADDR || in_master_ack_i) begin
                out_valid_d = 1'b1;
                kind_d      = KIND_REPLY;
                rsel_d      = 3'd0;
                sbit_d      = 1'b0;
                rdat_d      = count_field(cnt_q);
                last_d      = 1'b1;
              end
            end
            CMD_SCAN: begin
              out_valid_d = 1'b1;
              kind_d      = KIND_LATCH;
              rsel_d      = row_field(row_q);
              sbit_d      = 1'b0;
              rdat_d      = 5'd0;
              last_d      = 1'b0;
              row_d       = row_next;
              addr_d      = ADDR_W'(row_next * BYTES_PER_ROW);
              mem_rd.en   = 1'b1;
              mem_rd.addr = ADDR_W'(row_next * BYTES_PER_ROW);
              bcnt_d      = '0;
              bit_d       = 3'd0;
              state_d     = S_BITS;
            end
            default: begin
            end
          endcase
        end
      end
      S_BITS: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          kind_d      = KIND_SHIFT;
          rsel_d      = 3'd0;
          rdat_d      = 5'd0;
          last_d      = last_bit;
          // First bit of a byte comes straight from the memory read register
          if (bit_q == 3'd0) begin
            sbit_d = mem_rdata[7];
            sh_d   = {mem_rdata[6:0], 1'b0};
          end else begin
            sbit_d = sh_q[7];
            sh_d   = {sh_q[6:0], 1'b0};
          end
          bit_d = bit_q + 1'b1;
          if (bit_q == 3'd7) begin
            if (last_bit) begin
              state_d = S_IDLE;
            end else begin
              bcnt_d      = bcnt_q + 1'b1;
              addr_d      = addr_q + 1'b1;
              mem_rd.en   = 1'b1;
              mem_rd.addr = addr_q + 1'b1;
            end
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      row_q       <= '0;
      addr_q      <= '0;
      bcnt_q      <= '0;
      bit_q       <= 3'd0;
      sh_q        <= 8'h00;
      out_valid_q <= 1'b0;
      kind_q      <= KIND_LATCH;
      rsel_q      <= 3'd0;
      sbit_q      <= 1'b0;
      rdat_q      <= 5'd0;
      last_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      row_q       <= row_d;
      addr_q      <= addr_d;
      bcnt_q      <= bcnt_d;
      bit_q       <= bit_d;
      sh_q        <= sh_d;
      out_valid_q <= out_valid_d;
      kind_q      <= kind_d;
      rsel_q      <= rsel_d;
      sbit_q      <= sbit_d;
      rdat_q      <= rdat_d;
      last_q      <= last_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_kind_o       = kind_q;
  assign out_row_select_o = rsel_q;
  assign out_serial_bit_o = sbit_q;
  assign out_read_data_o  = rdat_q;
  assign out_last_o       = last_q;

`ifndef SYNTH
  a_cnt_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(FRAME_BYTES))
    else $error("write count beyond frame size");

  a_reply_only_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_kind_o != KIND_REPLY |-> out_read_data_o == 5'd0)
    else $error("read data on a non-reply item");

  a_latch_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_kind_o == KIND_LATCH |-> !out_last_o)
    else $error("latch item flagged last");

  a_latch_then_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && out_kind_o == KIND_LATCH |=> state_q == S_BITS)
    else $error("scan left before its serial bits");
`endif

endmodule

FILE: hw/rtl/lmsb_frame_mem.sv
// Frame store: single-write, single-read memory with per-entry valid bits for reset contents.
module lmsb_frame_mem
  import lmsb_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  mem_wr_t    wr_i,
  input  mem_rd_t    rd_i,
  output logic [7:0] rd_data_o
);

  logic [7:0]             mem [FRAME_BYTES];
  logic [FRAME_BYTES-1:0] valid_q;
  logic [7:0]             rd_data_q;
  logic [MEM_AW-1:0]      wr_idx;
  logic [MEM_AW-1:0]      rd_idx;
  logic                   wr_in_range;
  logic                   rd_in_range;

  assign wr_idx      = wr_i.addr[MEM_AW-1:0];
  assign rd_idx      = rd_i.addr[MEM_AW-1:0];
  assign wr_in_range = wr_i.addr < ADDR_W'(FRAME_BYTES);
  assign rd_in_range = rd_i.addr < ADDR_W'(FRAME_BYTES);

  always_ff @(posedge clk_i) begin
    if (wr_i.en && wr_in_range) begin
      mem[wr_idx] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_i.en && wr_in_range) begin
      valid_q[wr_idx] <= 1'b1;
    end
  end

  // Out-of-store bytes read as zero; unwritten entries read their power-on value
  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      if (!rd_in_range) begin
        rd_data_q <= 8'h00;
      end else if (valid_q[rd_idx]) begin
        rd_data_q <= mem[rd_idx];
      end else begin
        rd_data_q <= frame_init(rd_idx);
      end
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: test/led_matrix_scan_with_bus_loaded_frame_core_test.sv
// Self-checking testbench for the LED matrix scan core with bus-loaded frame store.
`timescale 1ns / 1ps

module led_matrix_scan_with_bus_loaded_frame_core_test;
  import lmsb_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    kind_e      kind;
    logic [2:0] row;
    logic       sbit;
    logic [4:0] count;
    logic       fin;
  } lamp_result_t;

  logic       clk_i           = 1'b0;
  logic       rst_ni          = 1'b0;
  logic       in_valid_i      = 1'b0;
  logic       in_stall_o;
  logic [2:0] in_cmd_i        = 3'd0;
  logic [7:0] in_data_byte_i  = 8'd0;
  logic       in_master_ack_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i     = 1'b0;
  logic [1:0] out_kind_o;
  logic [2:0] out_row_select_o;
  logic       out_serial_bit_o;
  logic [4:0] out_read_data_o;
  logic       out_last_o;

  // Shadow of the block state
  logic [7:0] frame_copy [FRAME_BYTES];
  int         fill_count;
  int         scan_row;

  lamp_result_t due_results [$];
  lamp_result_t oldest_due;
  int           mismatches;
  int           live_items;
  int           cycle_count;
  int           stall_left;
  bit           tx_calm;
  bit           rx_calm;

  led_matrix_scan_with_bus_loaded_frame_core uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .in_cmd_i        (in_cmd_i),
    .in_data_byte_i  (in_data_byte_i),
    .in_master_ack_i (in_master_ack_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_kind_o      (out_kind_o),
    .out_row_select_o(out_row_select_o),
    .out_serial_bit_o(out_serial_bit_o),
    .out_read_data_o (out_read_data_o),
    .out_last_o      (out_last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic flag_mismatch(input string what, input int got, input int want);
    mismatches++;
    $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
  endtask

  // Works out the results one accepted item gives and queues them
  task automatic model_matrix_step(input logic [2:0] cmd, input logic [7:0] data,
                                   input logic ack);
    lamp_result_t r;
    logic [7:0]   q;
    int           idx;
    r = '0;
    case (cmd)
      CMD_START: fill_count = 0;
      CMD_WRITE: begin
        if (fill_count < FRAME_BYTES) begin
          frame_copy[fill_count] = data;
          fill_count++;
        end
      end
      CMD_READ_ADDR, CMD_READ_NEXT: begin
        if (cmd == CMD_READ_ADDR || ack) begin
          r.kind  = KIND_REPLY;
          r.count = 5'(fill_count);
          r.fin   = 1'b1;
          due_results.push_back(r);
        end
      end
      CMD_SCAN: begin
        r.kind = KIND_LATCH;
        r.row  = 3'(scan_row);
        due_results.push_back(r);
        scan_row = (scan_row + 1) % ROWS;
        for (int b = 0; b < BYTES_PER_ROW; b++) begin
          idx = scan_row * BYTES_PER_ROW + b;
          q = (idx < FRAME_BYTES) ? frame_copy[idx] : 8'h00;
          for (int i = 0; i < 8; i++) begin
            r      = '0;
            r.kind = KIND_SHIFT;
            r.sbit = q[7-i];
            r.fin  = (b == BYTES_PER_ROW - 1 && i == 7);
            due_results.push_back(r);
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic send_item(input logic [2:0] cmd, input logic [7:0] data, input logic ack);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    in_cmd_i        <= cmd;
    in_data_byte_i  <= data;
    in_master_ack_i <= ack;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (cmd <= CMD_SCAN) live_items++;
    model_matrix_step(cmd, data, ack);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
  endtask

  // Result checker and receiver stall
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (due_results.size() == 0) begin
        flag_mismatch("result with nothing due, kind", out_kind_o, -1);
      end else begin
        oldest_due = due_results.pop_front();
        if (out_kind_o !== oldest_due.kind)
          flag_mismatch("kind", out_kind_o, oldest_due.kind);
        if (out_row_select_o !== oldest_due.row)
          flag_mismatch("row_select", out_row_select_o, oldest_due.row);
        if (out_serial_bit_o !== oldest_due.sbit)
          flag_mismatch("serial_bit", out_serial_bit_o, oldest_due.sbit);
        if (out_read_data_o !== oldest_due.count)
          flag_mismatch("read_data", out_read_data_o, oldest_due.count);
        if (out_last_o !== oldest_due.fin)
          flag_mismatch("last", out_last_o, oldest_due.fin);
      end
      stall_left = rx_calm ? 0 : $urandom_range(0, 17);
    end
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Eight ticks from reset: every row, the wrap, and the two marked bytes
  task automatic test_scan_from_reset();
    repeat (ROWS) send_item(CMD_SCAN, 8'h00, 1'b0);
  endtask

  task automatic test_bus_replies();
    send_item(CMD_READ_ADDR, 8'h00, 1'b0);
    send_item(CMD_READ_NEXT, 8'hff, 1'b0);
    send_item(CMD_READ_NEXT, 8'h00, 1'b1);
    send_item(CMD_START, 8'h00, 1'b0);
    send_item(CMD_WRITE, 8'hff, 1'b0);
    send_item(CMD_WRITE, 8'h00, 1'b1);
    send_item(CMD_WRITE, 8'h80, 1'b0);
    send_item(CMD_WRITE, 8'h01, 1'b0);
    send_item(CMD_READ_ADDR, 8'h00, 1'b0);
    send_item(CMD_READ_NEXT, 8'h00, 1'b1);
    send_item(CMD_SCAN, 8'h00, 1'b0);
  endtask

  task automatic test_unused_cmds();
    send_item(3'd5, 8'hff, 1'b1);
    send_item(3'd6, 8'h00, 1'b0);
    send_item(3'd7, 8'hff, 1'b1);
  endtask

  // Overfill the store: writes past the end are dropped, the count holds
  task automatic test_full_frame();
    send_item(CMD_START, 8'h00, 1'b0);
    repeat (FRAME_BYTES + 2) send_item(CMD_WRITE, 8'($urandom), 1'b0);
    send_item(CMD_READ_ADDR, 8'h00, 1'b0);
    send_item(CMD_READ_NEXT, 8'h00, 1'b1);
    repeat (ROWS) send_item(CMD_SCAN, 8'h00, 1'b0);
  endtask

  task automatic test_random_traffic(input int item_goal);
    int stop_at;
    int pick;
    int n;
    stop_at = live_items + item_goal;
    while (live_items < stop_at) begin
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      pick    = $urandom_range(0, 9);
      if (pick <= 5) begin
        // frame load, read back, then a few ticks
        send_item(CMD_START, 8'($urandom), 1'($urandom));
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 27) : $urandom_range(0, 8);
        repeat (n) send_item(CMD_WRITE, 8'($urandom), 1'($urandom));
        send_item(CMD_READ_ADDR, 8'($urandom), 1'($urandom));
        send_item(CMD_READ_NEXT, 8'($urandom), ($urandom_range(0, 3) != 0));
        repeat ($urandom_range(1, 4)) send_item(CMD_SCAN, 8'($urandom), 1'($urandom));
      end else if (pick <= 7) begin
        repeat ($urandom_range(1, 3)) send_item(CMD_SCAN, 8'($urandom), 1'($urandom));
      end else begin
        repeat ($urandom_range(1, 4))
          send_item(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom));
      end
    end
  endtask

  initial begin
    for (int i = 0; i < FRAME_BYTES; i++) frame_copy[i] = 8'h00;
    frame_copy[MARK_IDX_A] = MARK_BYTE;
    frame_copy[MARK_IDX_B] = MARK_BYTE;
    fill_count  = 0;
    scan_row    = 0;
    mismatches  = 0;
    live_items  = 0;
    cycle_count = 0;
    stall_left  = 0;
    tx_calm     = 1'b0;
    rx_calm     = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_scan_from_reset();
    test_bus_replies();
    test_unused_cmds();
    wait_drained();
    test_full_frame();
    test_random_traffic(70);

    wait_drained();
    repeat (40) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
